// ===== hw/rtl/source_char_tokenizer_core_assert.svh =====
// Assertion macros shared by the tokenizer RTL files.
// Each macro expects signals named clock and reset in the using module.
`ifndef SOURCE_CHAR_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_CHAR_TOKENIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stc_pkg.sv =====
// Shared types and constants of the source character tokenizer.
// No dependencies; every other RTL file but the assertion header imports this package.
package stc_pkg;

   localparam int POS_WIDTH_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int POS_OUT_WIDTH       = 16;
   localparam int TOKEN_KIND_WIDTH    = 5;
   localparam int CHAR_WIDTH          = 8;
   localparam int CSR_ADDR_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int CFG_WIDTH           = 16;

   localparam logic [CFG_WIDTH-1:0] START_ROW_RESET = 16'd1;
   localparam logic [CFG_WIDTH-1:0] START_COL_RESET = 16'd0;

   // Register index, taken from address bit 2.
   localparam logic CSR_IDX_START_ROW = 1'b0;
   localparam logic CSR_IDX_START_COL = 1'b1;

   typedef enum logic [TOKEN_KIND_WIDTH-1:0] {
      TOK_EOF         = 5'd0,
      TOK_DEF         = 5'd1,
      TOK_VAR         = 5'd2,
      TOK_KW_RETURN   = 5'd3,
      TOK_KW_STRUCT   = 5'd4,
      TOK_IDENT       = 5'd5,
      TOK_LIT_NUMBER  = 5'd6,
      TOK_SEP_COMMA   = 5'd7,
      TOK_SEMI        = 5'd8,
      TOK_LPAREN      = 5'd9,
      TOK_RPAREN      = 5'd10,
      TOK_LBRACE      = 5'd11,
      TOK_RBRACE      = 5'd12,
      TOK_LBRACKET    = 5'd13,
      TOK_RBRACKET    = 5'd14,
      TOK_ANG_LESS    = 5'd15,
      TOK_ANG_GREATER = 5'd16,
      TOK_STAR        = 5'd17,
      TOK_PLUS        = 5'd18,
      TOK_MINUS       = 5'd19,
      TOK_EQUAL       = 5'd20
   } token_kind_type;

   typedef struct packed {
      token_kind_type             kind;
      logic [POS_OUT_WIDTH-1:0]   row;
      logic [POS_OUT_WIDTH-1:0]   col;
   } token_type;

   // One queue entry holds every result of one item: one or two tokens.
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] start_row;
      logic [CFG_WIDTH-1:0] start_col;
   } cfg_type;

endpackage

// ===== hw/rtl/stc_channel_if.sv =====
// Valid/ready channel interfaces for the tokenizer input and result streams.
// Depends on stc_pkg for the payload widths.
interface stc_req_if import stc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [CHAR_WIDTH-1:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface stc_rsp_if import stc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [TOKEN_KIND_WIDTH-1:0] token_kind;
   logic [POS_OUT_WIDTH-1:0]    row_now;
   logic [POS_OUT_WIDTH-1:0]    col_now;
   logic                        last_of_run;

   modport source (output valid, output token_kind, output row_now, output col_now,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input row_now, input col_now,
                   input last_of_run, output ready);
endinterface

// ===== hw/rtl/stc_front.sv =====
// Front end of the tokenizer: accepts characters, tracks word and position state.
// Depends on stc_pkg, the channel interfaces and the assertion macro header.
`include "source_char_tokenizer_core_assert.svh"

module stc_front import stc_pkg::*; #(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   stc_req_if.sink          req,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_data
);

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   localparam logic [47:0] KW_DEF    = 48'h000000646566;
   localparam logic [47:0] KW_VAR    = 48'h000000766172;
   localparam logic [47:0] KW_RETURN = 48'h72657475726E;
   localparam logic [47:0] KW_STRUCT = 48'h737472756374;

   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_POINT    = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LESS     = 8'h3C;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_GREATER  = 8'h3E;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;

   localparam logic [2:0] LEN_MAX  = 3'd7;
   localparam logic [2:0] LEN_KEEP = 3'd6;
   localparam logic [2:0] LEN_3    = 3'd3;

   function automatic logic [POS_WIDTH-1:0] clamp_pos(input logic [CFG_WIDTH-1:0] v);
      logic [31:0] v32;
      logic [31:0] max32;
      begin
         v32   = 32'(v);
         max32 = 32'(POS_MAX);
         clamp_pos = (v32 > max32) ? POS_MAX : POS_WIDTH'(v32);
      end
   endfunction

   function automatic token_kind_type punct_code(input logic [7:0] c);
      case (c)
         CH_COMMA:    punct_code = TOK_SEP_COMMA;
         CH_SEMI:     punct_code = TOK_SEMI;
         CH_LPAREN:   punct_code = TOK_LPAREN;
         CH_RPAREN:   punct_code = TOK_RPAREN;
         CH_LBRACE:   punct_code = TOK_LBRACE;
         CH_RBRACE:   punct_code = TOK_RBRACE;
         CH_LBRACKET: punct_code = TOK_LBRACKET;
         CH_RBRACKET: punct_code = TOK_RBRACKET;
         CH_LESS:     punct_code = TOK_ANG_LESS;
         CH_GREATER:  punct_code = TOK_ANG_GREATER;
         CH_STAR:     punct_code = TOK_STAR;
         CH_PLUS:     punct_code = TOK_PLUS;
         CH_MINUS:    punct_code = TOK_MINUS;
         CH_EQUAL:    punct_code = TOK_EQUAL;
         default:     punct_code = TOK_EOF;
      endcase
   endfunction

   function automatic logic ends_word(input logic [7:0] c);
      ends_word = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACKET) ||
                  (c == CH_RBRACKET) || (c == CH_LESS) || (c == CH_GREATER) ||
                  (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_SPACE) ||
                  (c == CH_NEWLINE);
   endfunction

   function automatic token_kind_type word_kind(input logic [2:0] len,
                                                input logic [47:0] prefix,
                                                input logic all_num);
      if (len == LEN_3 && prefix == KW_DEF) begin
         word_kind = TOK_DEF;
      end else if (len == LEN_3 && prefix == KW_VAR) begin
         word_kind = TOK_VAR;
      end else if (len == LEN_KEEP && prefix == KW_RETURN) begin
         word_kind = TOK_KW_RETURN;
      end else if (len == LEN_KEEP && prefix == KW_STRUCT) begin
         word_kind = TOK_KW_STRUCT;
      end else begin
         word_kind = all_num ? TOK_LIT_NUMBER : TOK_IDENT;
      end
   endfunction

   logic                 in_word_ff, in_word_in;
   logic                 in_comment_ff, in_comment_in;
   logic [2:0]           len_ff, len_in;
   logic [47:0]          prefix_ff, prefix_in;
   logic                 all_num_ff, all_num_in;
   logic                 point_ff, point_in;
   logic [POS_WIDTH-1:0] row_ff, row_in;
   logic [POS_WIDTH-1:0] col_ff, col_in;

   logic                 accept;
   logic [7:0]           c;
   logic                 cont;
   token_kind_type       punct;
   token_kind_type       cur_kind;
   logic [POS_WIDTH-1:0] row_inc, col_inc;
   logic [2:0]           base_len, add_len;
   logic [47:0]          base_prefix, add_prefix;
   logic                 base_all, base_point, add_all, add_point;
   logic                 is_point, is_digit;
   logic                 push_c;
   entry_type            ent;
   token_type            word_tok, eof_tok, punct_tok;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign c         = req.char_code;

   assign cont     = in_word_ff && !ends_word(c);
   assign punct    = punct_code(c);
   assign cur_kind = word_kind(len_ff, prefix_ff, all_num_ff);
   assign row_inc  = (row_ff == POS_MAX) ? row_ff : row_ff + 1'b1;
   assign col_inc  = (col_ff == POS_MAX) ? col_ff : col_ff + 1'b1;

   // A character either extends the pending word or starts a fresh one.
   assign base_len    = cont ? len_ff : 3'd0;
   assign base_prefix = cont ? prefix_ff : 48'd0;
   assign base_all    = cont ? all_num_ff : 1'b1;
   assign base_point  = cont ? point_ff : 1'b0;
   assign is_point    = (c == CH_POINT);
   assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
   assign add_len     = (base_len == LEN_MAX) ? LEN_MAX : base_len + 1'b1;
   assign add_prefix  = (base_len < LEN_KEEP) ? {base_prefix[39:0], c} : base_prefix;
   assign add_point   = base_point || is_point;
   assign add_all     = base_all && (is_point ? !base_point : is_digit);

   assign word_tok  = '{kind: cur_kind, row: POS_OUT_WIDTH'(row_ff),
                        col: POS_OUT_WIDTH'(col_ff)};
   assign eof_tok   = '{kind: TOK_EOF, row: POS_OUT_WIDTH'(row_ff),
                        col: POS_OUT_WIDTH'(col_ff)};
   assign punct_tok = '{kind: punct, row: POS_OUT_WIDTH'(row_ff),
                        col: POS_OUT_WIDTH'(col_inc)};

   always_comb begin
      in_word_in    = in_word_ff;
      in_comment_in = in_comment_ff;
      len_in        = len_ff;
      prefix_in     = prefix_ff;
      all_num_in    = all_num_ff;
      point_in      = point_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      push_c        = 1'b0;
      ent           = '0;

      if (req.kind) begin
         // End of input: flush a pending word, then eof, then reload position.
         push_c = 1'b1;
         if (in_word_ff) begin
            ent.two    = 1'b1;
            ent.first  = word_tok;
            ent.second = eof_tok;
         end else begin
            ent.first = eof_tok;
         end
         in_word_in    = 1'b0;
         in_comment_in = 1'b0;
         len_in        = 3'd0;
         prefix_in     = 48'd0;
         all_num_in    = 1'b1;
         point_in      = 1'b0;
         row_in        = clamp_pos(cfg.start_row);
         col_in        = clamp_pos(cfg.start_col);
      end else if (in_comment_ff) begin
         if (c == CH_NEWLINE) begin
            in_comment_in = 1'b0;
            col_in        = '0;
            row_in        = row_inc;
         end
      end else if (cont) begin
         len_in     = add_len;
         prefix_in  = add_prefix;
         all_num_in = add_all;
         point_in   = add_point;
         col_in     = col_inc;
      end else begin
         if (in_word_ff) begin
            push_c     = 1'b1;
            ent.first  = word_tok;
            in_word_in = 1'b0;
            len_in     = 3'd0;
            prefix_in  = 48'd0;
            all_num_in = 1'b1;
            point_in   = 1'b0;
         end
         if (punct != TOK_EOF) begin
            push_c = 1'b1;
            col_in = col_inc;
            if (in_word_ff) begin
               ent.two    = 1'b1;
               ent.second = punct_tok;
            end else begin
               ent.first = punct_tok;
            end
         end else if (c == CH_HASH) begin
            in_comment_in = 1'b1;
         end else if (c == CH_NEWLINE) begin
            col_in = '0;
            row_in = row_inc;
         end else if (c == CH_SPACE) begin
            col_in = col_inc;
         end else begin
            in_word_in = 1'b1;
            len_in     = add_len;
            prefix_in  = add_prefix;
            all_num_in = add_all;
            point_in   = add_point;
            col_in     = col_inc;
         end
      end
   end

   assign push      = accept && push_c;
   assign push_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff    <= 1'b0;
         in_comment_ff <= 1'b0;
         len_ff        <= 3'd0;
         prefix_ff     <= 48'd0;
         all_num_ff    <= 1'b1;
         point_ff      <= 1'b0;
         row_ff        <= clamp_pos(START_ROW_RESET);
         col_ff        <= clamp_pos(START_COL_RESET);
      end else if (accept) begin
         in_word_ff    <= in_word_in;
         in_comment_ff <= in_comment_in;
         len_ff        <= len_in;
         prefix_ff     <= prefix_in;
         all_num_ff    <= all_num_in;
         point_ff      <= point_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

   `STC_ASSERT_SAME(a_word_not_comment, 1'b1, !(in_word_ff && in_comment_ff), "word in comment")
   `STC_ASSERT_SAME(a_len_tracks_word, 1'b1, in_word_ff == (len_ff != '0), "bad word length")
   `STC_ASSERT_SAME(a_push_has_room, push, !q_status.full, "push into a full queue")

endmodule

// ===== hw/rtl/stc_queue.sv =====
// Small result queue between the tokenizer front end and back end.
// Depends on stc_pkg and the assertion macro header.
`include "source_char_tokenizer_core_assert.svh"

module stc_queue import stc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign pop_data     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `STC_ASSERT_SAME(a_no_pop_empty, pop, !status.empty, "pop from an empty queue")
   `STC_ASSERT_SAME(a_no_push_full, push, !status.full, "push into a full queue")
   `STC_ASSERT_NEXT(a_count_moves, push && !pop, count_ff == $past(count_ff) + 1'b1, "lost push")

endmodule

// ===== hw/rtl/stc_back.sv =====
// Back end of the tokenizer: drains queue entries one token per cycle while rsp is ready.
// Depends on stc_pkg, the channel interfaces and the assertion macro header.
`include "source_char_tokenizer_core_assert.svh"

module stc_back import stc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        pop_data,
   output logic             pop,
   stc_rsp_if.source        rsp
);

   entry_type cur_ff, cur_in;
   logic      busy_ff, busy_in;
   logic      second_ff, second_in;
   logic      is_last;
   logic      take;
   token_type tok;

   assign tok     = second_ff ? cur_ff.second : cur_ff.first;
   assign is_last = second_ff || !cur_ff.two;
   assign take    = busy_ff && rsp.ready;
   assign pop     = (!busy_ff || (take && is_last)) && !q_status.empty;

   assign rsp.valid       = busy_ff;
   assign rsp.token_kind  = tok.kind;
   assign rsp.row_now     = tok.row;
   assign rsp.col_now     = tok.col;
   assign rsp.last_of_run = is_last;

   always_comb begin
      cur_in    = cur_ff;
      busy_in   = busy_ff;
      second_in = second_ff;
      if (pop) begin
         cur_in    = pop_data;
         busy_in   = 1'b1;
         second_in = 1'b0;
      end else if (take && is_last) begin
         busy_in   = 1'b0;
         second_in = 1'b0;
      end else if (take) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `STC_ASSERT_SAME(a_second_only_pairs, second_ff, busy_ff && cur_ff.two, "second of a single")
   `STC_ASSERT_SAME(a_pop_when_free, pop, !busy_ff || take, "pop while busy")
   `STC_ASSERT_NEXT(a_rsp_held, rsp.valid && !rsp.ready, rsp.valid && $stable(tok), "result lost")

endmodule

// ===== hw/rtl/source_char_tokenizer_core.sv =====
// Source character tokenizer top level: front end, result queue, back end, CSRs.
// Depends on stc_pkg, stc_channel_if, stc_front, stc_queue and stc_back.
// A token is written into the queue, then loaded into the back end's registers, before rsp offers it.
// The front end takes one character per cycle while the queue is not full; each token leaves
// in a cycle of its own, so the two tokens of a character leave on rsp one after the other.
// Reset clears the word and comment state and loads row 1, column 0.
module source_char_tokenizer_core import stc_pkg::*; #(
   parameter int POS_WIDTH   = POS_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   stc_req_if.sink                   req_chan,
   stc_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // The front end classifies one character per cycle and writes every result
   // of that character as one entry into the queue. It stalls only when the
   // queue is full. The back end takes entries out and presents their tokens
   // one at a time from its own registers, so a stalled consumer never blocks
   // the front end until the queue has filled.

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   queue_status_type q_status;
   logic             push, pop;
   entry_type        push_data, pop_data;

   // Configuration registers. A new start row or column is only used at the
   // next end of input; the counters themselves are not touched by a write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_START_ROW: cfg_in.start_row = csr_pwdata[CFG_WIDTH-1:0];
            CSR_IDX_START_COL: cfg_in.start_col = csr_pwdata[CFG_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_START_ROW: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.start_row);
         CSR_IDX_START_COL: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.start_col);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_row <= START_ROW_RESET;
         cfg_ff.start_col <= START_COL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: word, comment and position tracking.
   stc_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Queue of per-character result entries.
   stc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Back end: serializes each entry onto the result channel.
   stc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for source_char_tokenizer_core: drives characters,
// predicts the token stream and compares every result token in order.
// Depends on the RTL package stc_pkg and the channel interfaces in stc_channel_if.
module tb_top;
   import stc_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 3;
   // Room for the pipeline registers and the result queue to empty, with margin.
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 60;
   localparam int PHASE_COUNT   = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int SCRIPT_LEN    = 25;

   // Keyword spellings, right-aligned in the six-byte prefix.
   localparam logic [47:0] KW_DEF    = {24'h0, "def"};
   localparam logic [47:0] KW_VAR    = {24'h0, "var"};
   localparam logic [47:0] KW_RETURN = "return";
   localparam logic [47:0] KW_STRUCT = "struct";

   typedef struct packed {
      token_kind_type           kind;
      logic [POS_OUT_WIDTH-1:0] row;
      logic [POS_OUT_WIDTH-1:0] col;
      logic                     last;
   } token_rec;

   localparam token_rec NO_TOKEN = '0;

   // A hand-written expectation that travels with one item; when typed is
   // clear, the predicted tokens are used instead.
   typedef struct packed {
      logic     typed;
      token_rec tok;
   } hand_expect;

   typedef struct {
      logic       eof_flag;
      logic [7:0] ch;
      logic       typed;
      token_rec   tok;
   } script_row;

   logic clock = 1'b0;
   logic reset;

   stc_req_if req_chan ();
   stc_rsp_if rsp_chan ();

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   source_char_tokenizer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Tokenizer state as the testbench sees it, plus the start position that
   // the next end of input will load.
   logic                 lx_in_word;
   logic                 lx_in_comment;
   logic [2:0]           lx_len;
   logic [47:0]          lx_prefix;
   logic                 lx_numeric;
   logic                 lx_point;
   logic [15:0]          lx_row;
   logic [15:0]          lx_col;
   logic [CFG_WIDTH-1:0] cfg_row;
   logic [CFG_WIDTH-1:0] cfg_col;

   token_rec   step_out [2];
   int         step_count;
   token_rec   expected_tokens [$];
   hand_expect hand_q [$];

   int mismatch_count  = 0;
   int items_sent      = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   string keywords [4] = '{"def", "var", "return", "struct"};
   string punct_chars  = ",;(){}[]<>*+-=";
   string word_ends    = "()[]<>,; \n";

   script_row opening_script [SCRIPT_LEN];

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_word_end(logic [7:0] c);
      case (c)
         "(", ")", "[", "]", "<", ">", ",", ";", " ", "\n": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // TOK_EOF stands for "not a single-character token" here.
   function automatic token_kind_type punct_kind(logic [7:0] c);
      case (c)
         ",": return TOK_SEP_COMMA;
         ";": return TOK_SEMI;
         "(": return TOK_LPAREN;
         ")": return TOK_RPAREN;
         "{": return TOK_LBRACE;
         "}": return TOK_RBRACE;
         "[": return TOK_LBRACKET;
         "]": return TOK_RBRACKET;
         "<": return TOK_ANG_LESS;
         ">": return TOK_ANG_GREATER;
         "*": return TOK_STAR;
         "+": return TOK_PLUS;
         "-": return TOK_MINUS;
         "=": return TOK_EQUAL;
         default: return TOK_EOF;
      endcase
   endfunction

   function automatic void clear_word();
      lx_in_word = 1'b0;
      lx_len     = 3'd0;
      lx_prefix  = '0;
      lx_numeric = 1'b1;
      lx_point   = 1'b0;
   endfunction

   function automatic void grow_word(logic [7:0] c);
      lx_in_word = 1'b1;
      if (lx_len < 3'd6) begin
         lx_prefix = {lx_prefix[39:0], c};
      end
      if (lx_len < 3'd7) begin
         lx_len = lx_len + 3'd1;
      end
      if (c == ".") begin
         if (lx_point) begin
            lx_numeric = 1'b0;
         end
         lx_point = 1'b1;
      end else if (c < "0" || c > "9") begin
         lx_numeric = 1'b0;
      end
      lx_col = sat_inc(lx_col);
   endfunction

   function automatic token_kind_type word_class();
      if (lx_len == 3'd3 && lx_prefix == KW_DEF) return TOK_DEF;
      if (lx_len == 3'd3 && lx_prefix == KW_VAR) return TOK_VAR;
      if (lx_len == 3'd6 && lx_prefix == KW_RETURN) return TOK_KW_RETURN;
      if (lx_len == 3'd6 && lx_prefix == KW_STRUCT) return TOK_KW_STRUCT;
      return lx_numeric ? TOK_LIT_NUMBER : TOK_IDENT;
   endfunction

   function automatic void emit_token(token_kind_type k);
      step_out[step_count] = '{kind: k, row: lx_row, col: lx_col, last: 1'b0};
      step_count++;
   endfunction

   // Advances the tokenizer by one item and leaves its tokens in step_out.
   function automatic int lex_step(logic eof_flag, logic [7:0] ch);
      token_kind_type p;
      step_count = 0;
      if (eof_flag) begin
         if (lx_in_word) begin
            emit_token(word_class());
         end
         emit_token(TOK_EOF);
         clear_word();
         lx_in_comment = 1'b0;
         lx_row = cfg_row;
         lx_col = cfg_col;
      end else if (lx_in_comment) begin
         if (ch == "\n") begin
            lx_in_comment = 1'b0;
            lx_col = '0;
            lx_row = sat_inc(lx_row);
         end
      end else if (lx_in_word && !is_word_end(ch)) begin
         grow_word(ch);
      end else begin
         // The pending word closes first; its terminator is handled below.
         if (lx_in_word) begin
            emit_token(word_class());
            clear_word();
         end
         p = punct_kind(ch);
         if (p != TOK_EOF) begin
            lx_col = sat_inc(lx_col);
            emit_token(p);
         end else if (ch == "#") begin
            lx_in_comment = 1'b1;
         end else if (ch == "\n") begin
            lx_col = '0;
            lx_row = sat_inc(lx_row);
         end else if (ch == " ") begin
            lx_col = sat_inc(lx_col);
         end else begin
            grow_word(ch);
         end
      end
      if (step_count > 0) begin
         step_out[step_count-1].last = 1'b1;
      end
      return step_count;
   endfunction

   // Predict on every accepted item and check every accepted token. Both
   // sides are sampled at the clock edge, before that edge's updates land.
   always @(posedge clock) begin : scoreboard
      hand_expect hx;
      token_rec   want;
      int         n;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            n  = lex_step(req_chan.kind, req_chan.char_code);
            hx = hand_q.pop_front();
            if (hx.typed) begin
               expected_tokens.push_back(hx.tok);
            end else begin
               for (int i = 0; i < n; i++) begin
                  expected_tokens.push_back(step_out[i]);
               end
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tokens.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("token with nothing expected: kind %0d row %0d col %0d last %0b",
                           rsp_chan.token_kind, rsp_chan.row_now, rsp_chan.col_now,
                           rsp_chan.last_of_run);
               end
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_chan.token_kind !== want.kind || rsp_chan.row_now !== want.row ||
                   rsp_chan.col_now !== want.col || rsp_chan.last_of_run !== want.last) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("token mismatch: expected kind %0d row %0d col %0d last %0b",
                              want.kind, want.row, want.col, want.last);
                     $display("                got      kind %0d row %0d col %0d last %0b",
                              rsp_chan.token_kind, rsp_chan.row_now, rsp_chan.col_now,
                              rsp_chan.last_of_run);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   // The receiver stalls at the rate of the current phase.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one item, after random idle cycles, and returns at the clock edge
   // that accepts it. The valid line stays high, so the next call may drive
   // the following item in the same step without lowering it first.
   task automatic send_char(logic eof_flag, logic [7:0] ch, logic typed, token_rec tok);
      hand_expect hx;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      hx.typed = typed;
      hx.tok   = tok;
      hand_q.push_back(hx);
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= eof_flag;
      req_chan.char_code <= ch;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic put(logic [7:0] ch);
      send_char(1'b0, ch, 1'b0, NO_TOKEN);
   endtask

   // The character byte of an end-of-input item is don't-care, so it is random.
   task automatic put_eof();
      send_char(1'b1, 8'($urandom_range(255)), 1'b0, NO_TOKEN);
   endtask

   // Writes both start registers back to back, then updates the copy that
   // the predictor loads at the next end of input.
   task automatic write_start_pos(logic [CFG_WIDTH-1:0] row_val, logic [CFG_WIDTH-1:0] col_val);
      for (int i = 0; i < 2; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {(i == 0) ? CSR_IDX_START_ROW : CSR_IDX_START_COL, 2'b00};
         csr_pwdata  <= CSR_DATA_WIDTH'((i == 0) ? row_val : col_val);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_row = row_val;
      cfg_col = col_val;
   endtask

   // Lowers valid, waits for every expected token, then lets the pipeline
   // settle so items without tokens are finished too.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0 || hand_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One word followed by a terminator or, now and then, by end of input.
   task automatic send_word();
      logic [7:0] text [$];
      string      kw;
      logic [7:0] c;
      case ($urandom_range(4))
         0: begin
            kw = keywords[$urandom_range(3)];
            for (int j = 0; j < kw.len(); j++) text.push_back(kw[j]);
         end
         1: begin
            repeat ($urandom_range(1, 5)) text.push_back(8'("a" + $urandom_range(25)));
         end
         2: begin
            // Numbers, including a lone point and a few with two points.
            if ($urandom_range(9) == 0) begin
               text.push_back(".");
            end else begin
               repeat ($urandom_range(1, 4)) text.push_back(8'("0" + $urandom_range(9)));
               if ($urandom_range(1) == 1) begin
                  text.push_back(".");
                  repeat ($urandom_range(3)) text.push_back(8'("0" + $urandom_range(9)));
                  if ($urandom_range(4) == 0) begin
                     text.push_back(".");
                  end
               end
            end
         end
         3: begin
            // Near misses: one letter more or one less than a keyword.
            kw = keywords[$urandom_range(3)];
            for (int j = 0; j < kw.len(); j++) text.push_back(kw[j]);
            if ($urandom_range(1) == 1) begin
               text.push_back("s");
            end else begin
               void'(text.pop_back());
            end
         end
         default: begin
            // Long words of arbitrary bytes, past the six kept in the prefix.
            repeat ($urandom_range(7, 10)) begin
               do c = 8'($urandom_range(255)); while (is_word_end(c));
               text.push_back(c);
            end
         end
      endcase
      foreach (text[j]) put(text[j]);
      if ($urandom_range(9) == 0) begin
         put_eof();
      end else begin
         put(word_ends[$urandom_range(9)]);
      end
   endtask

   // Mostly well-formed source fragments, with some raw bytes as noise.
   task automatic send_fragment();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_word();
      end else if (pick < 55) begin
         put(punct_chars[$urandom_range(13)]);
      end else if (pick < 65) begin
         put(" ");
      end else if (pick < 73) begin
         put("\n");
      end else if (pick < 80) begin
         put("#");
         repeat ($urandom_range(3)) put(8'($urandom_range(255)));
         put("\n");
      end else if (pick < 84) begin
         put_eof();
      end else begin
         put(8'($urandom_range(255)));
      end
   endtask

   initial begin : stimulus
      logic [CFG_WIDTH-1:0] phase_row [PHASE_COUNT];
      logic [CFG_WIDTH-1:0] phase_col [PHASE_COUNT];
      int                   first_item;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = 1'b0;
      req_chan.char_code = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;

      // The predictor starts from the reset state of the block.
      cfg_row = START_ROW_RESET;
      cfg_col = START_COL_RESET;
      clear_word();
      lx_in_comment = 1'b0;
      lx_row = cfg_row;
      lx_col = cfg_col;

      // Directed opening: end of input straight after reset, punctuation, a
      // keyword closed by a comma, a comment over a high byte, a lone point,
      // words holding braces and odd bytes, a number with two points, end
      // of input inside a comment, and positions after the reload.
      opening_script = '{
         '{1'b1, 8'hFF, 1'b1, '{TOK_EOF,        16'd1, 16'd0,  1'b1}},
         '{1'b0, "(",   1'b1, '{TOK_LPAREN,     16'd1, 16'd1,  1'b1}},
         '{1'b0, "d",   1'b0, NO_TOKEN},
         '{1'b0, "e",   1'b0, NO_TOKEN},
         '{1'b0, "f",   1'b0, NO_TOKEN},
         '{1'b0, ",",   1'b0, NO_TOKEN},
         '{1'b0, "#",   1'b0, NO_TOKEN},
         '{1'b0, 8'hFF, 1'b0, NO_TOKEN},
         '{1'b0, "\n",  1'b0, NO_TOKEN},
         '{1'b0, ".",   1'b0, NO_TOKEN},
         '{1'b0, " ",   1'b1, '{TOK_LIT_NUMBER, 16'd2, 16'd1,  1'b1}},
         '{1'b0, 8'hFF, 1'b0, NO_TOKEN},
         '{1'b0, 8'h00, 1'b0, NO_TOKEN},
         '{1'b0, "{",   1'b0, NO_TOKEN},
         '{1'b0, ";",   1'b0, NO_TOKEN},
         '{1'b0, "1",   1'b0, NO_TOKEN},
         '{1'b0, "2",   1'b0, NO_TOKEN},
         '{1'b0, ".",   1'b0, NO_TOKEN},
         '{1'b0, ".",   1'b0, NO_TOKEN},
         '{1'b0, ">",   1'b0, NO_TOKEN},
         '{1'b0, "#",   1'b0, NO_TOKEN},
         '{1'b1, 8'h00, 1'b1, '{TOK_EOF,        16'd2, 16'd11, 1'b1}},
         '{1'b0, "=",   1'b1, '{TOK_EQUAL,      16'd1, 16'd1,  1'b1}},
         '{1'b0, "\n",  1'b0, NO_TOKEN},
         '{1'b0, "+",   1'b1, '{TOK_PLUS,       16'd2, 16'd1,  1'b1}}
      };

      // Start positions per random phase: the extremes, values that
      // saturate after a few steps, and random ones.
      phase_row = '{16'd1, 16'hFFFF, 16'd0, 16'hFFFE, 16'd0, 16'd0, 16'hFFFF, 16'd0};
      phase_col = '{16'd0, 16'hFFFF, 16'd0, 16'hFFF8, 16'd0, 16'hFFFF, 16'd0, 16'd0};
      phase_row[4] = CFG_WIDTH'($urandom);
      phase_col[4] = CFG_WIDTH'($urandom);
      phase_row[7] = CFG_WIDTH'($urandom);
      phase_col[7] = CFG_WIDTH'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_start_pos(START_ROW_RESET, START_COL_RESET);
      foreach (opening_script[i]) begin
         send_char(opening_script[i].eof_flag, opening_script[i].ch,
                   opening_script[i].typed, opening_script[i].tok);
      end
      drain();

      // Random phases cycle through the idling patterns: none, sender idle,
      // receiver stalling, and both lightly.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 52; end
            default: begin sender_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         write_start_pos(phase_row[p], phase_col[p]);
         // End of input first, so the new start position is loaded at once.
         put_eof();
         first_item = items_sent;
         while (items_sent - first_item < PHASE_ITEMS) begin
            send_fragment();
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("source_char_tokenizer_core test passed");
      end else begin
         $display("source_char_tokenizer_core test failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("source_char_tokenizer_core test failed");
      $finish;
   end

endmodule
